FILE: rtl/type_record_hash_indexer_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the record hash indexer
// Shared concurrent assertion forms, clocked and gated by the sync reset.
// ---------------------------------------------------------------------------
`ifndef TYPE_RECORD_HASH_INDEXER_MACROS_SVH
`define TYPE_RECORD_HASH_INDEXER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define TRHI_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// Next-cycle implication, disabled while reset is asserted
`define TRHI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

FILE: rtl/trhi_pkg.sv
// ---------------------------------------------------------------------------
// Record hash indexer package
// Beat types, phase encoding, register map and the CRC / bucket functions.
// ---------------------------------------------------------------------------
package trhi_pkg;

    // Configuration register map
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_TYPE_INDEX  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_GRANULARITY = 2'd1;

    localparam logic [31:0] FIRST_TYPE_INDEX_RST  = 32'h0000_1000;
    localparam logic [31:0] INDEX_GRANULARITY_RST = 32'd8192;

    // Reflected CRC-32 polynomial and bucket modulus (2^18 - 1)
    localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
    localparam logic [17:0] BUCKET_COUNT = 18'h3FFFF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_in_buffer;
    } t_in_beat;

    typedef struct packed {
        logic [31:0] type_index;
        logic [31:0] blob_offset;
        logic [17:0] hash_bucket;
        logic        index_entry;
    } t_out_beat;

    typedef enum logic [1:0] {
        PH_LEN_LO  = 2'd0,
        PH_LEN_HI  = 2'd1,
        PH_PAYLOAD = 2'd2
    } t_phase;

    // One byte of reflected CRC-32, bit at a time
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

    // Value modulo 2^18 - 1 by end-around folding
    function automatic logic [17:0] bucket_mod(input logic [31:0] v);
        logic [18:0] s1;
        logic [18:0] s2;
        s1 = {1'b0, v[17:0]} + {5'd0, v[31:18]};
        s2 = {1'b0, s1[17:0]} + {18'd0, s1[18]};
        return (s2[17:0] == BUCKET_COUNT) ? 18'd0 : s2[17:0];
    endfunction

endpackage

FILE: rtl/type_record_hash_indexer.sv
// ---------------------------------------------------------------------------
// Record hash indexer
// Splits a byte stream into length-prefixed records and hashes each one.
// ---------------------------------------------------------------------------
// Takes one byte per cycle while the output side takes results: each beat
// lands in an input register and, once the result slot is free or draining,
// a single pass of logic advances the record parser, folds the byte into a
// running reflected CRC-32 seeded with zero and, on a record's final byte,
// loads the result register with type index, blob offset, CRC modulo
// 2^18-1 and the index-entry flag. The byte-wide CRC update followed by the
// bucket fold sets the critical path. A length below 2 drops the rest of
// the buffer, and a record cut off by the buffer end gives no result.
module type_record_hash_indexer (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  trhi_pkg::t_in_beat                    i_in_beat,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output trhi_pkg::t_out_beat                   o_out_beat,
    input  logic                                  i_cfg_we,
    input  logic [trhi_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [trhi_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import trhi_pkg::*;

    // Configuration
    logic [31:0] r_first_type_index;
    logic [31:0] r_index_granularity;

    // Input register
    logic        r_in_valid;
    t_in_beat    r_in_beat;

    // Parser state
    t_phase      r_phase, n_phase;
    logic        r_dropping, n_dropping;
    logic [7:0]  r_length_low, n_length_low;
    logic [15:0] r_bytes_left, n_bytes_left;
    logic [16:0] r_record_size, n_record_size;
    logic [31:0] r_crc, n_crc;
    logic [31:0] r_accepted_bytes, n_accepted_bytes;
    logic [31:0] r_record_count, n_record_count;
    logic [31:0] r_last_indexed, n_last_indexed;

    // Result register
    logic        r_out_valid, n_out_valid;
    t_out_beat   r_out_beat, n_out_beat;

    logic        w_proc;
    logic [15:0] w_len;
    logic        w_len_short;
    logic [15:0] w_bytes_dec;
    logic        w_rec_done;
    logic        w_emit;
    logic [31:0] w_crc_in;
    logic [31:0] w_crc_nx;
    logic [31:0] w_off_delta;
    logic        w_flag;

    // Advance the held beat when the result slot is free or draining
    assign w_proc     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_proc;

    assign w_len       = {r_in_beat.data_byte, r_length_low};
    assign w_len_short = (w_len < 16'd2);
    assign w_bytes_dec = r_bytes_left - 16'd1;
    assign w_rec_done  = !r_dropping && (r_phase == PH_PAYLOAD) && (w_bytes_dec == 16'd0);
    assign w_emit      = w_proc && w_rec_done;

    // CRC restarts at zero on a length low byte
    assign w_crc_in = (r_phase == PH_LEN_LO) ? 32'd0 : r_crc;
    assign w_crc_nx = crc_byte(w_crc_in, r_in_beat.data_byte);

    // Index entry on the first record or once the offset moved far enough
    assign w_off_delta = r_accepted_bytes - r_last_indexed;
    assign w_flag      = (r_record_count == 32'd0) || (w_off_delta >= r_index_granularity);

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (w_proc) begin
            if (!r_dropping) begin
                unique case (r_phase)
                    PH_LEN_LO:  n_phase = PH_LEN_HI;
                    PH_LEN_HI:  n_phase = w_len_short ? PH_LEN_LO : PH_PAYLOAD;
                    PH_PAYLOAD: n_phase = w_rec_done ? PH_LEN_LO : PH_PAYLOAD;
                    default:    n_phase = PH_LEN_LO;
                endcase
            end
            if (r_in_beat.last_in_buffer) begin
                n_phase = PH_LEN_LO;
            end
        end
    end

    // Datapath and result
    always_comb begin
        n_dropping       = r_dropping;
        n_length_low     = r_length_low;
        n_bytes_left     = r_bytes_left;
        n_record_size    = r_record_size;
        n_crc            = r_crc;
        n_accepted_bytes = r_accepted_bytes;
        n_record_count   = r_record_count;
        n_last_indexed   = r_last_indexed;
        n_out_beat       = r_out_beat;
        n_out_valid      = r_out_valid && !i_out_ready;

        if (w_proc) begin
            n_out_valid = w_emit;
            if (!r_dropping) begin
                n_crc = w_crc_nx;
                unique case (r_phase)
                    PH_LEN_LO: begin
                        n_length_low = r_in_beat.data_byte;
                    end
                    PH_LEN_HI: begin
                        if (w_len_short) begin
                            n_dropping = 1'b1;
                        end else begin
                            n_bytes_left  = w_len;
                            n_record_size = {1'b0, w_len} + 17'd2;
                        end
                    end
                    PH_PAYLOAD: begin
                        n_bytes_left = w_bytes_dec;
                    end
                    default: begin
                        n_crc = r_crc;
                    end
                endcase
            end
            if (w_emit) begin
                n_out_beat.type_index  = r_first_type_index + r_record_count;
                n_out_beat.blob_offset = r_accepted_bytes;
                n_out_beat.hash_bucket = bucket_mod(w_crc_nx);
                n_out_beat.index_entry = w_flag;
                if (w_flag) begin
                    n_last_indexed = r_accepted_bytes;
                end
                n_accepted_bytes = r_accepted_bytes + {15'd0, r_record_size};
                n_record_count   = r_record_count + 32'd1;
            end
            if (r_in_beat.last_in_buffer) begin
                n_dropping = 1'b0;
            end
        end
    end

    // Control registers and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_type_index  <= FIRST_TYPE_INDEX_RST;
            r_index_granularity <= INDEX_GRANULARITY_RST;
            r_in_valid          <= 1'b0;
            r_phase             <= PH_LEN_LO;
            r_dropping          <= 1'b0;
            r_accepted_bytes    <= 32'd0;
            r_record_count      <= 32'd0;
            r_last_indexed      <= 32'd0;
            r_out_valid         <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_FIRST_TYPE_INDEX:  r_first_type_index  <= i_cfg_data;
                    CFG_INDEX_GRANULARITY: r_index_granularity <= i_cfg_data;
                    default: ;
                endcase
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            r_phase          <= n_phase;
            r_dropping       <= n_dropping;
            r_accepted_bytes <= n_accepted_bytes;
            r_record_count   <= n_record_count;
            r_last_indexed   <= n_last_indexed;
            r_out_valid      <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_beat <= i_in_beat;
        end
        r_length_low  <= n_length_low;
        r_bytes_left  <= n_bytes_left;
        r_record_size <= n_record_size;
        r_crc         <= n_crc;
        r_out_beat    <= n_out_beat;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

endmodule

FILE: rtl/trhi_checker.sv
// ---------------------------------------------------------------------------
// Record hash indexer port checker
// Watches the top-level ports for handshake and result-range slips.
// ---------------------------------------------------------------------------
`include "type_record_hash_indexer_macros.svh"

module trhi_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                o_in_ready,
    input  logic                o_out_valid,
    input  logic                i_out_ready,
    input  trhi_pkg::t_out_beat o_out_beat
);
    import trhi_pkg::*;

    // Hold a stalled result beat
    `TRHI_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_beat))

    // Accept input whenever no result is pending
    `TRHI_ASSERT_SAME(a_ready_when_empty, i_clk, i_rst_n, !o_out_valid, o_in_ready)

    // Keep the bucket below the modulus
    `TRHI_ASSERT_SAME(a_bucket_range, i_clk, i_rst_n, o_out_valid, o_out_beat.hash_bucket != BUCKET_COUNT)

endmodule

bind type_record_hash_indexer trhi_checker u_trhi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_beat  (o_out_beat)
);

FILE: dv/type_record_hash_indexer_tb.sv
// ---------------------------------------------------------------------------
// Record hash indexer testbench
// Drives buffers of length-prefixed records and checks every result beat
// against a cycle-free predictor of the parser, the reflected CRC-32 bucket
// and the index-entry flag. Covers register reset values, special cases,
// spare indexes, register sweeps and random traffic, with random idle and stall bursts.
// ---------------------------------------------------------------------------
module type_record_hash_indexer_tb;
    import trhi_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned SETTLE_CYCLES  = 16;
    // Spare register indexes: writes there must have no effect
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    t_in_beat              i_in_beat   = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b1;
    t_out_beat             o_out_beat;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    type_record_hash_indexer u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_beat  (o_out_beat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Predictor state: registers and record parser
    logic [31:0] cfg_first_index   = FIRST_TYPE_INDEX_RST;
    logic [31:0] cfg_granularity   = INDEX_GRANULARITY_RST;
    t_phase      parse_phase       = PH_LEN_LO;
    logic [7:0]  len_low_byte      = '0;
    logic [15:0] payload_left      = '0;
    logic [16:0] record_bytes      = '0;
    logic [31:0] crc_acc           = '0;
    logic [31:0] blob_bytes        = '0;
    logic [31:0] records_seen      = '0;
    logic [31:0] last_entry_offset = '0;
    logic        skip_to_end       = 1'b0;

    t_out_beat   expected_records[$];
    logic [7:0]  buf_q[$];
    int unsigned mismatch_count = 0;
    int unsigned items_sent     = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned stall_left     = 0;
    logic        traffic_idle   = 1'b0;

    function automatic logic [31:0] jamcrc_update(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        repeat (8) c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        return c;
    endfunction

    function automatic void restart_record();
        parse_phase  = PH_LEN_LO;
        len_low_byte = '0;
        payload_left = '0;
        record_bytes = '0;
        crc_acc      = '0;
    endfunction

    // Advance the parser by one accepted byte; queue a result on record end
    function automatic void predict_beat(input logic [7:0] b, input logic last);
        logic [15:0] rec_len;
        t_out_beat   rec;
        if (!skip_to_end) begin
            case (parse_phase)
                PH_LEN_LO: begin
                    len_low_byte = b;
                    crc_acc      = jamcrc_update(32'd0, b);
                    parse_phase  = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    rec_len = {b, len_low_byte};
                    crc_acc = jamcrc_update(crc_acc, b);
                    if (rec_len < 16'd2) begin
                        skip_to_end = 1'b1;
                        restart_record();
                    end else begin
                        payload_left = rec_len;
                        record_bytes = {1'b0, rec_len} + 17'd2;
                        parse_phase  = PH_PAYLOAD;
                    end
                end
                default: begin
                    crc_acc      = jamcrc_update(crc_acc, b);
                    payload_left = payload_left - 16'd1;
                    if (payload_left == 16'd0) begin
                        rec.type_index  = cfg_first_index + records_seen;
                        rec.blob_offset = blob_bytes;
                        rec.hash_bucket = 18'(crc_acc % {14'd0, BUCKET_COUNT});
                        rec.index_entry = (records_seen == 32'd0) ||
                                          ((blob_bytes - last_entry_offset) >= cfg_granularity);
                        if (rec.index_entry) last_entry_offset = blob_bytes;
                        expected_records = {expected_records, rec};
                        blob_bytes   = blob_bytes + {15'd0, record_bytes};
                        records_seen = records_seen + 32'd1;
                        restart_record();
                    end
                end
            endcase
        end
        if (last) begin
            restart_record();
            skip_to_end = 1'b0;
        end
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // Send one byte; valid stays high on return so back-to-back beats flow
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (traffic_idle && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_beat  <= '{data_byte: b, last_in_buffer: last};
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_beat(b, last);
        items_sent++;
    endtask

    // Send buf_q as one buffer, last marked on its final byte
    task automatic send_buffer();
        foreach (buf_q[i]) send_byte(buf_q[i], i == buf_q.size() - 1);
        buf_q.delete();
    endtask

    function automatic void push_record(input logic [15:0] len, input int unsigned payload_n);
        buf_q = {buf_q, len[7:0]};
        buf_q = {buf_q, len[15:8]};
        repeat (payload_n) buf_q = {buf_q, 8'($urandom)};
    endfunction

    // Drop valid, wait for every expected result, then let the pipe settle
    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_records.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_FIRST_TYPE_INDEX:  cfg_first_index = value;
            CFG_INDEX_GRANULARITY: cfg_granularity = value;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Reset register values: first record flagged, type index from 4096
    task automatic test_reset_defaults();
        traffic_idle = 1'b0;
        buf_q = '{8'h02, 8'h00, 8'h00, 8'h00, 8'h02, 8'h00, 8'hFF, 8'hFF};
        send_buffer();
        drain();
    endtask

    // Short lengths, cut-off records, lone length byte, type index wrap
    task automatic test_special_cases();
        write_reg(CFG_FIRST_TYPE_INDEX, 32'hFFFF_FFFF);
        write_reg(CFG_INDEX_GRANULARITY, 32'd0);
        traffic_idle = 1'b1;
        // record, then a zero length that drops the rest
        buf_q = '{8'h02, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hAA};
        send_buffer();
        // length of one, ending the buffer on its high byte
        buf_q = '{8'h01, 8'h00};
        send_buffer();
        buf_q = '{8'h7F};
        send_buffer();
        // maximum length, cut off
        buf_q = '{8'hFF, 8'hFF, 8'h12, 8'h34};
        send_buffer();
        // record that completes on the buffer end
        buf_q = '{8'h03, 8'h00, 8'h80, 8'h01, 8'hFE};
        send_buffer();
        drain();
    endtask

    // Writes to spare indexes must not disturb either register
    task automatic test_spare_index();
        write_reg(CFG_SPARE_LO, 32'hFFFF_FFFF);
        write_reg(CFG_SPARE_HI, 32'h0000_0000);
        traffic_idle = 1'b0;
        buf_q = '{8'h02, 8'h00, 8'h5A, 8'hA5};
        send_buffer();
        drain();
    endtask

    // Random buffers under one register setting
    task automatic test_random_traffic(input int unsigned n_items, input logic [31:0] first_idx,
                                       input logic [31:0] granularity, input logic idle);
        int unsigned stop_at;
        int unsigned kind;
        int unsigned n_rec;
        logic [15:0] len;
        write_reg(CFG_FIRST_TYPE_INDEX, first_idx);
        write_reg(CFG_INDEX_GRANULARITY, granularity);
        traffic_idle = idle;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            kind  = $urandom_range(0, 15);
            n_rec = (kind <= 10) ? $urandom_range(1, 4) : $urandom_range(0, 2);
            // well-formed records, mostly short
            repeat (n_rec) begin
                len = ($urandom_range(0, 15) == 0) ? 16'($urandom_range(100, 400))
                                                  : 16'($urandom_range(2, 24));
                push_record(len, int'(len));
            end
            if (kind == 11 || kind == 12) begin
                // record cut off by the buffer end
                if ($urandom_range(0, 3) == 0) begin
                    buf_q = {buf_q, 8'($urandom)};
                end else begin
                    len = 16'($urandom_range(2, 65535));
                    push_record(len, $urandom_range(0, (len > 16'd20) ? 20 : int'(len) - 1));
                end
            end else if (kind == 13) begin
                // short length, then junk that must be dropped
                push_record(16'($urandom_range(0, 1)), $urandom_range(0, 6));
            end else if (kind >= 14) begin
                repeat ($urandom_range(1, 12)) buf_q = {buf_q, 8'($urandom)};
            end
            send_buffer();
        end
        drain();
    endtask

    // Output side: random stall bursts while traffic idling is on
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
        end else if (traffic_idle && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 5);
        end
        i_out_ready <= (stall_left == 0);
    end

    // Compare each result beat with the oldest expected record
    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_records.size() == 0) begin
                report_mismatch($sformatf("unexpected result beat %h", o_out_beat));
            end else begin
                want = expected_records.pop_front();
                if (o_out_beat.type_index !== want.type_index)
                    report_mismatch($sformatf("type_index got %h want %h",
                                              o_out_beat.type_index, want.type_index));
                if (o_out_beat.blob_offset !== want.blob_offset)
                    report_mismatch($sformatf("blob_offset got %0d want %0d",
                                              o_out_beat.blob_offset, want.blob_offset));
                if (o_out_beat.hash_bucket !== want.hash_bucket)
                    report_mismatch($sformatf("hash_bucket got %h want %h",
                                              o_out_beat.hash_bucket, want.hash_bucket));
                if (o_out_beat.index_entry !== want.index_entry)
                    report_mismatch($sformatf("index_entry got %b want %b",
                                              o_out_beat.index_entry, want.index_entry));
            end
        end
    end

    // Watchdog: end the run after too many cycles without a beat moving
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL type_record_hash_indexer");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_special_cases();
        test_spare_index();
        test_random_traffic(330, 32'h0000_0000, 32'd1, 1'b1);
        test_random_traffic(330, $urandom, 32'($urandom_range(2, 64)), 1'b1);
        test_random_traffic(330, 32'hFFFF_FFF0, 32'd0, 1'b0);
        test_random_traffic(330, $urandom, 32'hFFFF_FFFF, 1'b1);
        test_random_traffic(330, 32'hFFFF_FFFF, 32'($urandom_range(16, 200)), 1'b1);
        test_random_traffic(300, $urandom, 32'($urandom_range(1, 48)), 1'b0);
        if (mismatch_count == 0) begin
            $display("PASS type_record_hash_indexer");
        end else begin
            $display("FAIL type_record_hash_indexer");
        end
        $finish;
    end

endmodule
